>>> hw/rtl/canonical_json_spelling_checker_defines.svh
// Assertion macros for the checker file of this block.
// Each macro expects clk, and all but the last also rst_n, where it is used.
`ifndef CANONICAL_JSON_SPELLING_CHECKER_DEFINES_SVH
`define CANONICAL_JSON_SPELLING_CHECKER_DEFINES_SVH

// Same-cycle implication, ignored while reset is held.
`define CJSC_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is held.
`define CJSC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked across reset.
`define CJSC_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/cjsc_pkg.sv
package cjsc_pkg;

  // Default container nesting limit.
  localparam int unsigned MAX_DEPTH_DEF = 64;

  // Status codes reported with every word.
  typedef enum logic [3:0] {
    ST_OK               = 4'd0,
    ST_BOM              = 4'd1,
    ST_SOLIDUS          = 4'd2,
    ST_TRUNCATED        = 4'd3,
    ST_BAD_ESCAPE       = 4'd4,
    ST_SHORTER_ESCAPE   = 4'd5,
    ST_TRAILING         = 4'd6,
    ST_WHITESPACE       = 4'd7,
    ST_MINUS            = 4'd8,
    ST_FRAC_AFTER_DIGIT = 4'd9,
    ST_FRAC_OTHER       = 4'd10,
    ST_DEPTH_OVERFLOW   = 4'd11
  } status_t;

  // Progress through a leading byte order mark.
  typedef enum logic [1:0] {
    BOM_START,
    BOM_SEEN_EF,
    BOM_SEEN_EFBB,
    BOM_PAST
  } bom_state_t;

  // Position inside a \u escape: idle, or waiting for digit one to four.
  localparam logic [2:0] HEX_IDLE = 3'd0;
  localparam logic [2:0] HEX_D1   = 3'd1;
  localparam logic [2:0] HEX_D2   = 3'd2;
  localparam logic [2:0] HEX_D4   = 3'd4;

  // Byte values of interest.
  localparam logic [7:0] CH_BOM0     = 8'hEF;
  localparam logic [7:0] CH_BOM1     = 8'hBB;
  localparam logic [7:0] CH_BOM2     = 8'hBF;
  localparam logic [7:0] CH_QUOTE    = 8'h22;
  localparam logic [7:0] CH_BSLASH   = 8'h5C;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_LOWER_U  = 8'h75;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_NL       = 8'h0A;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_HEX_A    = 8'h61;
  localparam logic [7:0] CH_HEX_F    = 8'h66;

  // Controls that have a two-character escape, and the largest control.
  localparam logic [7:0] CTRL_MAX = 8'h1F;
  localparam logic [7:0] CTRL_BS  = 8'h08;
  localparam logic [7:0] CTRL_HT  = 8'h09;
  localparam logic [7:0] CTRL_LF  = 8'h0A;
  localparam logic [7:0] CTRL_FF  = 8'h0C;
  localparam logic [7:0] CTRL_CR  = 8'h0D;

  // One input word as held in the input register.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } item_t;

  // One result word as produced by the check logic.
  typedef struct packed {
    status_t status;
    logic    new_error;
    logic    message_end;
  } result_t;

endpackage

>>> hw/rtl/cjsc_in_if.sv
interface cjsc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

>>> hw/rtl/cjsc_out_if.sv
interface cjsc_out_if;
  logic       valid;
  logic       ready;
  logic [3:0] status;
  logic       new_error;
  logic       message_end;

  modport source (output valid, output status, output new_error, output message_end,
                  input ready);
  modport sink (input valid, input status, input new_error, input message_end,
                output ready);
endinterface

>>> hw/rtl/canonical_json_spelling_checker.sv
// Canonical JSON spelling checker.
// in_bus carries one byte of JSON text per word with last_byte marking the
// final byte of a message; out_bus returns exactly one word per input word:
// status holds the first spelling error of the message so far (zero when
// clean), new_error flags the byte that raised it, and message_end echoes
// last_byte, at which point status is final for that message.
// A word accepted into the input register is checked there against the message
// state, and its result enters the result register, which drives out_bus, as
// soon as that register is empty or being drained. The block takes one word
// per cycle while out_bus does not stall; the state update between the input
// register and the result register is combinational.
// When out_bus stalls, the result register holds its word and the input
// register still accepts one more word, so two words can be in flight.
// Reset empties both registers and clears all message state; after the last
// byte of a message the state returns to its start values by itself.
// MAX_DEPTH sets the deepest container nesting that is accepted.
module canonical_json_spelling_checker #(
  parameter int unsigned MAX_DEPTH = cjsc_pkg::MAX_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  cjsc_in_if.sink    in_bus,
  cjsc_out_if.source out_bus
);
  import cjsc_pkg::*;

  logic    fire;
  logic    adv;
  item_t   item;
  result_t result;

  // Input register.
  cjsc_in_stage u_in_stage (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .adv    (adv),
    .fire   (fire),
    .item   (item)
  );

  // Message state and spelling checks.
  cjsc_engine #(
    .MAX_DEPTH (MAX_DEPTH)
  ) u_engine (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (item),
    .result (result)
  );

  // Result register.
  cjsc_out_stage u_out_stage (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (fire),
    .result  (result),
    .adv     (adv),
    .out_bus (out_bus)
  );
endmodule

>>> hw/rtl/cjsc_in_stage.sv
module cjsc_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  cjsc_in_if.sink         in_bus,
  input  logic            adv,
  output logic            fire,
  output cjsc_pkg::item_t item
);
  import cjsc_pkg::*;

  logic  valid_r;
  item_t item_r;

  // The register takes a new word when empty or when its word moves on.
  assign in_bus.ready = !valid_r || adv;
  assign fire         = valid_r && adv;
  assign item         = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      valid_r <= in_bus.valid;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (in_bus.valid && in_bus.ready) begin
      item_r.data_byte <= in_bus.data_byte;
      item_r.last_byte <= in_bus.last_byte;
    end
  end
endmodule

>>> hw/rtl/cjsc_engine.sv
module cjsc_engine #(
  parameter int unsigned MAX_DEPTH = cjsc_pkg::MAX_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  cjsc_pkg::item_t   item,
  output cjsc_pkg::result_t result
);
  import cjsc_pkg::*;

  // Nesting saturates one above the limit.
  localparam int unsigned NW = $clog2(MAX_DEPTH + 2);
  localparam logic [NW-1:0] DEPTH_LIMIT = NW'(MAX_DEPTH);
  localparam logic [NW-1:0] DEPTH_SAT   = NW'(MAX_DEPTH + 1);
  localparam logic [NW-1:0] DEPTH_ONE   = NW'(1);

  logic          in_string_r, in_string_nxt;
  logic          after_bs_r, after_bs_nxt;
  logic [2:0]    hex_seen_r, hex_seen_nxt;
  logic          hex_bad_r, hex_bad_nxt;
  logic [7:0]    scalar_r, scalar_nxt;
  logic [NW-1:0] nesting_r, nesting_nxt;
  logic          root_done_r, root_done_nxt;
  logic          prev_digit_r, prev_digit_nxt;
  bom_state_t    bom_r, bom_nxt;
  status_t       first_err_r, first_err_nxt;

  logic [7:0] b;
  logic       last;
  logic       is_dec;
  logic       is_lo;
  logic [3:0] nib;
  logic       bom_hit;
  status_t    body_code;
  status_t    elem_code;
  status_t    raise_code;
  logic       new_err;

  // A decoded escape is too long when the control has a short form or is no control.
  function automatic logic has_short_form(input logic [7:0] s);
    has_short_form = (s > CTRL_MAX) ||
                     (s inside {CTRL_BS, CTRL_HT, CTRL_LF, CTRL_FF, CTRL_CR});
  endfunction

  assign b      = item.data_byte;
  assign last   = item.last_byte;
  assign is_dec = b inside {[CH_ZERO:CH_NINE]};
  assign is_lo  = b inside {[CH_HEX_A:CH_HEX_F]};
  assign nib    = is_dec ? b[3:0] : (is_lo ? (b[3:0] + 4'd9) : 4'd0);

  // Byte order mark detection at the start of a message.
  always_comb begin
    bom_nxt = bom_r;
    bom_hit = 1'b0;
    case (bom_r)
      BOM_START:     bom_nxt = (b == CH_BOM0) ? BOM_SEEN_EF : BOM_PAST;
      BOM_SEEN_EF:   bom_nxt = (b == CH_BOM1) ? BOM_SEEN_EFBB : BOM_PAST;
      BOM_SEEN_EFBB: begin
        bom_hit = (b == CH_BOM2);
        bom_nxt = BOM_PAST;
      end
      default:       bom_nxt = BOM_PAST;
    endcase
  end

  // String, escape and container tracking with the per-byte spelling checks.
  always_comb begin
    in_string_nxt = in_string_r;
    after_bs_nxt  = after_bs_r;
    hex_seen_nxt  = hex_seen_r;
    hex_bad_nxt   = hex_bad_r;
    scalar_nxt    = scalar_r;
    nesting_nxt   = nesting_r;
    root_done_nxt = root_done_r;
    body_code     = ST_OK;
    elem_code     = ST_OK;

    if (in_string_r) begin
      if (hex_seen_r != HEX_IDLE) begin
        // The first two digits must be zero; the last two form the scalar.
        if (hex_seen_r == HEX_D1 || hex_seen_r == HEX_D2) begin
          if (b != CH_ZERO) begin
            hex_bad_nxt = 1'b1;
          end
        end else begin
          if (!is_dec && !is_lo) begin
            hex_bad_nxt = 1'b1;
          end
          scalar_nxt = {scalar_r[3:0], nib};
        end
        if (hex_seen_r == HEX_D4) begin
          if (hex_bad_nxt) begin
            body_code = ST_BAD_ESCAPE;
          end else if (has_short_form(scalar_nxt)) begin
            body_code = ST_SHORTER_ESCAPE;
          end
          hex_seen_nxt = HEX_IDLE;
        end else begin
          hex_seen_nxt = hex_seen_r + 3'd1;
          if (last) begin
            body_code = ST_TRUNCATED;
          end
        end
      end else if (after_bs_r) begin
        after_bs_nxt = 1'b0;
        if (b == CH_SLASH) begin
          body_code = ST_SOLIDUS;
        end
        if (b == CH_LOWER_U) begin
          if (last) begin
            body_code = ST_TRUNCATED;
          end
          hex_seen_nxt = HEX_D1;
          hex_bad_nxt  = 1'b0;
          scalar_nxt   = 8'd0;
        end
      end else if (b == CH_BSLASH) begin
        after_bs_nxt = 1'b1;
      end else if (b == CH_QUOTE) begin
        in_string_nxt = 1'b0;
      end
    end else begin
      if (b == CH_QUOTE) begin
        in_string_nxt = 1'b1;
      end else if (b == CH_LBRACE || b == CH_LBRACKET) begin
        if (nesting_r >= DEPTH_LIMIT) begin
          elem_code   = ST_DEPTH_OVERFLOW;
          nesting_nxt = DEPTH_SAT;
        end else begin
          nesting_nxt = nesting_r + DEPTH_ONE;
        end
      end else if ((b == CH_RBRACE || b == CH_RBRACKET) && nesting_r != '0) begin
        nesting_nxt   = nesting_r - DEPTH_ONE;
        root_done_nxt = (nesting_r == DEPTH_ONE);
      end else if (b inside {CH_SPACE, CH_TAB, CH_CR, CH_NL}) begin
        elem_code = ST_WHITESPACE;
      end else if (b == CH_MINUS) begin
        elem_code = ST_MINUS;
      end else if (b == CH_DOT) begin
        elem_code = prev_digit_r ? ST_FRAC_AFTER_DIGIT : ST_FRAC_OTHER;
      end
      // Content after the closed root is reported ahead of its own fault.
      body_code = root_done_r ? ST_TRAILING : elem_code;
    end
  end

  // First error wins and then sticks for the rest of the message.
  always_comb begin
    prev_digit_nxt = is_dec;
    raise_code     = bom_hit ? ST_BOM : body_code;
    new_err        = (first_err_r == ST_OK) && (raise_code != ST_OK);
    first_err_nxt  = new_err ? raise_code : first_err_r;
    result.status      = first_err_nxt;
    result.new_error   = new_err;
    result.message_end = last;
  end

  // State update; the last byte of a message returns everything to start.
  always_ff @(posedge clk) begin
    if (!rst_n || (fire && last)) begin
      in_string_r  <= 1'b0;
      after_bs_r   <= 1'b0;
      hex_seen_r   <= HEX_IDLE;
      hex_bad_r    <= 1'b0;
      scalar_r     <= 8'd0;
      nesting_r    <= '0;
      root_done_r  <= 1'b0;
      prev_digit_r <= 1'b0;
      bom_r        <= BOM_START;
      first_err_r  <= ST_OK;
    end else if (fire) begin
      in_string_r  <= in_string_nxt;
      after_bs_r   <= after_bs_nxt;
      hex_seen_r   <= hex_seen_nxt;
      hex_bad_r    <= hex_bad_nxt;
      scalar_r     <= scalar_nxt;
      nesting_r    <= nesting_nxt;
      root_done_r  <= root_done_nxt;
      prev_digit_r <= prev_digit_nxt;
      bom_r        <= bom_nxt;
      first_err_r  <= first_err_nxt;
    end
  end
endmodule

>>> hw/rtl/cjsc_out_stage.sv
module cjsc_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  cjsc_pkg::result_t result,
  output logic              adv,
  cjsc_out_if.source        out_bus
);
  import cjsc_pkg::*;

  logic    valid_r;
  result_t result_r;

  // A new result may enter when the register is empty or being drained.
  assign adv = !valid_r || out_bus.ready;

  assign out_bus.valid       = valid_r;
  assign out_bus.status      = result_r.status;
  assign out_bus.new_error   = result_r.new_error;
  assign out_bus.message_end = result_r.message_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (adv) begin
      valid_r <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result_r <= result;
    end
  end
endmodule

>>> hw/rtl/cjsc_checker.sv
`include "canonical_json_spelling_checker_defines.svh"

module cjsc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [3:0] out_status,
  input logic       out_new_error,
  input logic       out_message_end
);
  import cjsc_pkg::*;

  // A stalled result word stays put.
  `CJSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_new_error) && $stable(out_message_end), "stalled result word changed")

  // Reset empties the result register and opens the input side.
  `CJSC_ASSERT_NEXT_ALWAYS(a_reset_out, !rst_n, !out_valid, "result valid after reset")
  `CJSC_ASSERT_NEXT_ALWAYS(a_reset_in, !rst_n, in_ready, "input not ready after reset")

  // Once an error is reported inside a message, the next word keeps it.
  `CJSC_ASSERT_IMPLY(a_sticky, (out_valid && out_ready && out_status != ST_OK && !out_message_end ##1 out_valid && out_ready), out_status == $past(out_status) && !out_new_error, "first error not kept")
endmodule

bind canonical_json_spelling_checker cjsc_checker u_cjsc_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_bus.ready),
  .out_valid       (out_bus.valid),
  .out_ready       (out_bus.ready),
  .out_status      (out_bus.status),
  .out_new_error   (out_bus.new_error),
  .out_message_end (out_bus.message_end)
);

>>> verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cjsc_pkg::*;

  localparam int unsigned DEPTH_LIMIT = MAX_DEPTH_DEF;

  // One row of the directed stimulus. When typed is set, the final repetition
  // is checked against the status written in the row instead of the predictor.
  typedef struct {
    logic [7:0]  data;
    logic        last;
    int unsigned reps;
    bit          typed;
    status_t     status;
    logic        fresh;
  } stim_row_t;

  logic clk;
  logic rst_n;

  cjsc_in_if  in_bus ();
  cjsc_out_if out_bus ();

  canonical_json_spelling_checker u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // Free-running clock, 4 ns period.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Message state of the spelling predictor.
  logic       str_open;
  logic       esc_pending;
  logic [2:0] hex_pos;
  logic       hex_fault;
  logic [7:0] esc_value;
  logic [6:0] depth_count;
  logic       root_closed;
  logic       digit_before;
  bom_state_t bom_step;
  status_t    err_code;
  logic       fresh_error;

  // Expected status words, oldest first.
  result_t status_due[$];

  // Bytes of the message being built for the random part.
  logic [7:0] msg_bytes[$];

  int send_idle_pct;
  int recv_idle_pct;
  int mismatch_count;
  int checked_words;
  int checked_messages;
  int raised_by_code [16];

  // Bytes that stress the checker when dropped into an otherwise clean text.
  logic [7:0] special_bytes [15] = '{CH_SPACE, CH_TAB, CH_CR, CH_NL, CH_MINUS, CH_DOT,
                                     CH_SLASH, CH_BSLASH, CH_QUOTE, CH_LOWER_U,
                                     CH_LBRACKET, CH_RBRACKET, CH_LBRACE, CH_RBRACE,
                                     CH_NINE};

  stim_row_t directed_rows [41] = '{
    '{8'h00,       1'b1, 1,  1'b1, ST_OK,               1'b0},
    '{CH_BOM0,     1'b0, 1,  1'b1, ST_OK,               1'b0},
    '{CH_BOM1,     1'b0, 1,  1'b1, ST_OK,               1'b0},
    '{CH_BOM2,     1'b1, 1,  1'b1, ST_BOM,              1'b1},
    '{CH_LBRACKET, 1'b1, 65, 1'b0, ST_OK,               1'b0},
    '{CH_RBRACKET, 1'b0, 1,  1'b1, ST_OK,               1'b0},
    '{CH_MINUS,    1'b1, 1,  1'b1, ST_MINUS,            1'b1},
    '{CH_QUOTE,    1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{CH_BSLASH,   1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{CH_SLASH,    1'b1, 1,  1'b1, ST_SOLIDUS,          1'b1},
    '{CH_QUOTE,    1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{CH_BSLASH,   1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{CH_LOWER_U,  1'b1, 1,  1'b1, ST_TRUNCATED,        1'b1},
    '{CH_QUOTE,    1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{CH_BSLASH,   1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{CH_LOWER_U,  1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{"x",         1'b1, 1,  1'b1, ST_TRUNCATED,        1'b1},
    '{CH_QUOTE,    1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{CH_BSLASH,   1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{CH_LOWER_U,  1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{CH_QUOTE,    1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{CH_BSLASH,   1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{"1",         1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{"F",         1'b1, 1,  1'b1, ST_BAD_ESCAPE,       1'b1},
    '{CH_QUOTE,    1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{CH_BSLASH,   1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{CH_LOWER_U,  1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{CH_ZERO,     1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{CH_ZERO,     1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{CH_ZERO,     1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{CH_HEX_A,    1'b1, 1,  1'b1, ST_SHORTER_ESCAPE,   1'b1},
    '{CH_LBRACE,   1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{CH_RBRACE,   1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{CH_SPACE,    1'b1, 1,  1'b1, ST_TRAILING,         1'b1},
    '{CH_TAB,      1'b1, 1,  1'b1, ST_WHITESPACE,       1'b1},
    '{"5",         1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{CH_DOT,      1'b1, 1,  1'b1, ST_FRAC_AFTER_DIGIT, 1'b1},
    '{CH_DOT,      1'b0, 1,  1'b1, ST_FRAC_OTHER,       1'b1},
    '{8'hFF,       1'b1, 1,  1'b1, ST_FRAC_OTHER,       1'b0},
    '{CH_QUOTE,    1'b0, 1,  1'b0, ST_OK,               1'b0},
    '{CH_BSLASH,   1'b1, 1,  1'b1, ST_OK,               1'b0}
  };

  // Return the predictor to the start of a message.
  function automatic void clear_message();
    str_open     = 1'b0;
    esc_pending  = 1'b0;
    hex_pos      = HEX_IDLE;
    hex_fault    = 1'b0;
    esc_value    = 8'h00;
    depth_count  = 7'd0;
    root_closed  = 1'b0;
    digit_before = 1'b0;
    bom_step     = BOM_START;
    err_code     = ST_OK;
  endfunction

  // Only the first error of a message is kept.
  function automatic void note_error(input status_t code);
    if (err_code == ST_OK) begin
      err_code    = code;
      fresh_error = 1'b1;
    end
  endfunction

  // Advance the message state by one byte and return the status word it causes.
  function automatic result_t check_spelling(input logic [7:0] b, input logic last);
    logic       is_dec;
    logic       is_hex_lo;
    logic [1:0] digit_idx;
    logic [3:0] nib;
    result_t    res;
    fresh_error = 1'b0;
    is_dec      = (b >= CH_ZERO) && (b <= CH_NINE);
    is_hex_lo   = (b >= CH_HEX_A) && (b <= CH_HEX_F);

    // A byte order mark is only looked for at the very start.
    case (bom_step)
      BOM_START:     bom_step = (b == CH_BOM0) ? BOM_SEEN_EF : BOM_PAST;
      BOM_SEEN_EF:   bom_step = (b == CH_BOM1) ? BOM_SEEN_EFBB : BOM_PAST;
      BOM_SEEN_EFBB: begin
        if (b == CH_BOM2) note_error(ST_BOM);
        bom_step = BOM_PAST;
      end
      default: ;
    endcase

    if (str_open) begin
      if (hex_pos != HEX_IDLE) begin
        // Any four bytes after a backslash-u count as its digits.
        digit_idx = hex_pos[1:0] - 2'd1;
        if (digit_idx < 2'd2) begin
          if (b != CH_ZERO) hex_fault = 1'b1;
        end else begin
          nib = is_dec ? b[3:0] : (is_hex_lo ? b[3:0] + 4'd9 : 4'd0);
          if (!is_dec && !is_hex_lo) hex_fault = 1'b1;
          esc_value = {esc_value[3:0], nib};
        end
        if (digit_idx == 2'd3) begin
          if (hex_fault) begin
            note_error(ST_BAD_ESCAPE);
          end else if (esc_value > CTRL_MAX || esc_value == CTRL_BS || esc_value == CTRL_HT ||
                       esc_value == CTRL_LF || esc_value == CTRL_FF || esc_value == CTRL_CR) begin
            note_error(ST_SHORTER_ESCAPE);
          end
          hex_pos = HEX_IDLE;
        end else begin
          hex_pos = hex_pos + 3'd1;
          if (last) note_error(ST_TRUNCATED);
        end
      end else if (esc_pending) begin
        esc_pending = 1'b0;
        if (b == CH_SLASH) note_error(ST_SOLIDUS);
        if (b == CH_LOWER_U) begin
          if (last) note_error(ST_TRUNCATED);
          hex_pos   = HEX_D1;
          hex_fault = 1'b0;
          esc_value = 8'h00;
        end
      end else if (b == CH_BSLASH) begin
        esc_pending = 1'b1;
      end else if (b == CH_QUOTE) begin
        str_open = 1'b0;
      end
    end else begin
      // Anything outside a string after the root closed is trailing content.
      if (root_closed) note_error(ST_TRAILING);
      if (b == CH_QUOTE) begin
        str_open = 1'b1;
      end else if (b == CH_LBRACE || b == CH_LBRACKET) begin
        if (depth_count >= DEPTH_LIMIT) begin
          note_error(ST_DEPTH_OVERFLOW);
          depth_count = 7'(DEPTH_LIMIT + 1);
        end else begin
          depth_count = depth_count + 7'd1;
        end
      end else if ((b == CH_RBRACE || b == CH_RBRACKET) && depth_count != 7'd0) begin
        depth_count = depth_count - 7'd1;
        root_closed = (depth_count == 7'd0);
      end else if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_NL) begin
        note_error(ST_WHITESPACE);
      end else if (b == CH_MINUS) begin
        note_error(ST_MINUS);
      end else if (b == CH_DOT) begin
        if (digit_before) note_error(ST_FRAC_AFTER_DIGIT);
        else note_error(ST_FRAC_OTHER);
      end
    end
    digit_before = is_dec;

    res.status      = err_code;
    res.new_error   = fresh_error;
    res.message_end = last;
    if (last) clear_message();
    return res;
  endfunction

  // Present one word and wait until it is taken; the expectation is recorded
  // at the accepting edge.
  task automatic send_byte(input logic [7:0] b, input logic last, input bit typed,
                           input status_t typed_status, input logic typed_fresh);
    result_t predicted;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
    end
    in_bus.valid     <= 1'b1;
    in_bus.data_byte <= b;
    in_bus.last_byte <= last;
    do @(posedge clk); while (!in_bus.ready);
    predicted = check_spelling(b, last);
    if (typed) begin
      predicted.status    = typed_status;
      predicted.new_error = typed_fresh;
    end
    status_due.insert(status_due.size(), predicted);
  endtask

  task automatic send_message();
    for (int i = 0; i < msg_bytes.size(); i++)
      send_byte(msg_bytes[i], i == msg_bytes.size() - 1, 1'b0, ST_OK, 1'b0);
  endtask

  // Append one byte to the message under construction.
  function automatic void put_byte(input logic [7:0] v);
    msg_bytes.insert(msg_bytes.size(), v);
  endfunction

  function automatic void push_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    return (nib < 4'd10) ? CH_ZERO + 8'(nib) : CH_HEX_A + 8'(nib) - 8'd10;
  endfunction

  // A string with plain text, short escapes, unicode escapes, control bytes and high bytes.
  function automatic void add_string();
    int unsigned n;
    logic [7:0]  code;
    string       short_pool;
    string       digit_pool;
    short_pool = "ntbfr\"\\/";
    digit_pool = "01af9Fg\"\\7";
    n = $urandom_range(0, 4);
    put_byte(CH_QUOTE);
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: begin
          put_byte(CH_BSLASH);
          put_byte(short_pool[$urandom_range(0, short_pool.len() - 1)]);
        end
        1: begin
          put_byte(CH_BSLASH);
          put_byte(CH_LOWER_U);
          if ($urandom_range(0, 3) != 0) begin
            code = 8'($urandom_range(0, 47));
            put_byte(CH_ZERO);
            put_byte(CH_ZERO);
            put_byte(hex_char(code[7:4]));
            put_byte(hex_char(code[3:0]));
          end else begin
            repeat (4) put_byte(digit_pool[$urandom_range(0, digit_pool.len() - 1)]);
          end
        end
        2: put_byte(8'($urandom_range(8'h80, 8'hFF)));
        3: put_byte(8'($urandom_range(8'h00, 8'h1F)));
        default: put_byte(8'($urandom_range("a", "z")));
      endcase
    end
    put_byte(CH_QUOTE);
  endfunction

  // A leaf value; numbers now and then carry a sign or a fraction.
  function automatic void add_scalar();
    int unsigned n;
    case ($urandom_range(0, 5))
      0, 1: add_string();
      2: begin
        if ($urandom_range(0, 7) == 0) put_byte(CH_MINUS);
        n = $urandom_range(1, 3);
        repeat (n) put_byte(8'($urandom_range(CH_ZERO, CH_NINE)));
        if ($urandom_range(0, 7) == 0) push_text(".5");
      end
      3: push_text("true");
      4: push_text("null");
      default: push_text("false");
    endcase
  endfunction

  // A container tree of random shape and content.
  function automatic void add_document();
    bit          obj_stack[$];
    int unsigned fill_stack[$];
    int unsigned budget;
    int unsigned top;
    bit          as_obj;
    budget = $urandom_range(1, 5);
    as_obj = $urandom_range(0, 1);
    obj_stack.insert(obj_stack.size(), as_obj);
    fill_stack.insert(fill_stack.size(), 0);
    put_byte(as_obj ? CH_LBRACE : CH_LBRACKET);
    while (obj_stack.size() != 0) begin
      top = obj_stack.size() - 1;
      if (budget == 0 || $urandom_range(0, 3) == 0) begin
        put_byte(obj_stack[top] ? CH_RBRACE : CH_RBRACKET);
        void'(obj_stack.pop_back());
        void'(fill_stack.pop_back());
      end else begin
        budget = budget - 1;
        if (fill_stack[top] != 0) push_text(",");
        fill_stack[top] = fill_stack[top] + 1;
        if (obj_stack[top]) begin
          add_string();
          push_text(":");
        end
        if ($urandom_range(0, 3) == 0 && obj_stack.size() < 5) begin
          as_obj = $urandom_range(0, 1);
          obj_stack.insert(obj_stack.size(), as_obj);
          fill_stack.insert(fill_stack.size(), 0);
          put_byte(as_obj ? CH_LBRACE : CH_LBRACKET);
        end else begin
          add_scalar();
        end
      end
    end
  endfunction

  // Mostly clean documents, some damaged, a little noise and the odd deep nest.
  function automatic void build_random_message();
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(0, 99);
    msg_bytes.delete();
    if (pick < 3) begin
      n = $urandom_range(DEPTH_LIMIT - 2, DEPTH_LIMIT + 2);
      repeat (n) put_byte($urandom_range(0, 1) ? CH_LBRACE : CH_LBRACKET);
      add_string();
      repeat (n) put_byte($urandom_range(0, 1) ? CH_RBRACE : CH_RBRACKET);
    end else if (pick < 8) begin
      n = $urandom_range(1, 8);
      repeat (n) put_byte(8'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 11))
        0: begin
          put_byte(CH_BOM0);
          put_byte(CH_BOM1);
          put_byte(CH_BOM2);
        end
        1: put_byte(CH_BOM0);
        2: begin
          put_byte(CH_BOM0);
          put_byte(CH_BOM1);
        end
        default: ;
      endcase
      add_document();
      if (pick >= 68) begin
        case ($urandom_range(0, 3))
          0: msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
          1: msg_bytes.insert($urandom_range(0, msg_bytes.size() - 1),
                              special_bytes[$urandom_range(0, 14)]);
          2: put_byte(special_bytes[$urandom_range(0, 14)]);
          default: begin
            n = $urandom_range(1, msg_bytes.size());
            while (msg_bytes.size() > n) void'(msg_bytes.pop_back());
          end
        endcase
      end
    end
  endfunction

  // Receiver side: ready drops at random in proportion to recv_idle_pct.
  always @(posedge clk) begin
    out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Compare each accepted status word with the oldest expectation.
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      checked_words = checked_words + 1;
      if (out_bus.message_end) checked_messages = checked_messages + 1;
      if (out_bus.new_error) raised_by_code[out_bus.status] = raised_by_code[out_bus.status] + 1;
      if (status_due.size() == 0) begin
        $display("%0t: word with no expectation: status %0d new_error %0b message_end %0b",
                 $time, out_bus.status, out_bus.new_error, out_bus.message_end);
        mismatch_count = mismatch_count + 1;
      end else begin
        want = status_due.pop_front();
        if (out_bus.status !== want.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.status, out_bus.status);
          mismatch_count = mismatch_count + 1;
        end
        if (out_bus.new_error !== want.new_error) begin
          $display("%0t: new_error expected %0b, actual %0b",
                   $time, want.new_error, out_bus.new_error);
          mismatch_count = mismatch_count + 1;
        end
        if (out_bus.message_end !== want.message_end) begin
          $display("%0t: message_end expected %0b, actual %0b",
                   $time, want.message_end, out_bus.message_end);
          mismatch_count = mismatch_count + 1;
        end
      end
    end
  end

  // Main sequence: reset, directed table, three random phases, drain.
  initial begin
    int    phase_bytes;
    string code_counts;
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = 8'h00;
    in_bus.last_byte = 1'b0;
    send_idle_pct    = 13;
    recv_idle_pct    = 68;
    mismatch_count   = 0;
    checked_words    = 0;
    checked_messages = 0;
    foreach (raised_by_code[i]) raised_by_code[i] = 0;
    clear_message();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      for (int unsigned k = 1; k <= directed_rows[r].reps; k++) begin
        send_byte(directed_rows[r].data, directed_rows[r].last && k == directed_rows[r].reps,
                  directed_rows[r].typed && k == directed_rows[r].reps,
                  directed_rows[r].status, directed_rows[r].fresh);
      end
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 13;
          recv_idle_pct = 68;
        end
        1: begin
          send_idle_pct = 68;
          recv_idle_pct = 13;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      phase_bytes = 0;
      while (phase_bytes < 95) begin
        build_random_message();
        phase_bytes = phase_bytes + msg_bytes.size();
        send_message();
      end
    end
    in_bus.valid <= 1'b0;

    // Let the pipeline empty, then wait on for stray words.
    while (status_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    code_counts = "";
    for (int i = 0; i <= ST_DEPTH_OVERFLOW; i++)
      code_counts = {code_counts, $sformatf(" %0d", raised_by_code[i])};
    $display("Checked %0d status words over %0d messages under three idle patterns.",
             checked_words, checked_messages);
    $display("First errors seen per code 0 to 11:%s", code_counts);
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Hard stop in case the handshake hangs.
  initial begin
    #2_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule
